/* rtl/assert_macros.svh */
// Assertion helpers, clocked on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define AST_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication
`define AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/k1d_pkg.sv */
package k1d_pkg;

    localparam int AXES      = 3;
    localparam int FIELD_W   = 32;
    localparam int CFG_W     = 25;
    localparam int VAR_W     = 26;
    localparam int FRAC_BITS = 16;
    localparam int POS_WIDTH = 32;
    localparam int IDX_W     = 2;
    localparam int DATA_W    = 32;

    localparam logic [CFG_W-1:0] CFG_MAX = {CFG_W{1'b1}};
    localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

    // Reset defaults 8.0 and 4.0, saturated to the register width
    localparam logic [63:0] VM_RAW = 64'd8 << FRAC_BITS;
    localparam logic [63:0] VP_RAW = 64'd4 << FRAC_BITS;
    localparam logic [CFG_W-1:0] VM_RESET =
        (VM_RAW > {39'd0, CFG_MAX}) ? CFG_MAX : VM_RAW[CFG_W-1:0];
    localparam logic [CFG_W-1:0] VP_RESET =
        (VP_RAW > {39'd0, CFG_MAX}) ? CFG_MAX : VP_RAW[CFG_W-1:0];

    typedef enum logic [IDX_W-1:0] {
        REG_MEAS_VAR = 2'd0,
        REG_PROC_VAR = 2'd1,
        REG_INIT_VAR = 2'd2,
        REG_NONE     = 2'd3
    } cfg_idx_t;

    // Control from the top level into one lane
    typedef struct packed {
        logic start;
        logic init;
        logic ack;
    } lane_ctl_t;

endpackage

/* rtl/kalman_1d_three_axis_top.sv */
// Three scalar Kalman filters (x, y, z) in signed fixed point. Each request either loads
// the estimate from the observation (action 1) or blends the observation into the
// estimate and then adds the displacement and the process variance (action 0); every
// request gives one result with the new estimates and variances. The axes run in three
// lanes side by side, each with a serial shift-add multiplier and a restoring divider.
// A step with both variances zero skips the multiply and divide, and an init request skips
// them too. One request is in work at a time; a new one can be taken while the previous
// result still waits at the output. Configuration writes are always ready and must be
// made while no request is in work.
module kalman_1d_three_axis_top #(
    parameter int POS_WIDTH = k1d_pkg::POS_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [k1d_pkg::IDX_W-1:0]           cfg_index,
    input  logic [k1d_pkg::DATA_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                action,
    input  logic signed [k1d_pkg::FIELD_W-1:0]  obs_x,
    input  logic signed [k1d_pkg::FIELD_W-1:0]  obs_y,
    input  logic signed [k1d_pkg::FIELD_W-1:0]  obs_z,
    input  logic signed [k1d_pkg::FIELD_W-1:0]  delta_x,
    input  logic signed [k1d_pkg::FIELD_W-1:0]  delta_y,
    input  logic signed [k1d_pkg::FIELD_W-1:0]  delta_z,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [k1d_pkg::FIELD_W-1:0]  est_x,
    output logic signed [k1d_pkg::FIELD_W-1:0]  est_y,
    output logic signed [k1d_pkg::FIELD_W-1:0]  est_z,
    output logic        [k1d_pkg::VAR_W-1:0]    var_x,
    output logic        [k1d_pkg::VAR_W-1:0]    var_y,
    output logic        [k1d_pkg::VAR_W-1:0]    var_z
);
    import k1d_pkg::*;

    logic [CFG_W-1:0]           vm_reg, vm_next;
    logic [CFG_W-1:0]           vp_reg, vp_next;
    logic [CFG_W-1:0]           iv_reg, iv_next;
    logic                       busy_reg, busy_next;
    logic                       accept, cfg_wr, load;
    lane_ctl_t                  ctl;
    logic [AXES-1:0]            lane_done;
    logic signed [FIELD_W-1:0]  lane_est [AXES];
    logic        [VAR_W-1:0]    lane_var [AXES];
    logic signed [FIELD_W-1:0]  obs_a [AXES];
    logic signed [FIELD_W-1:0]  dlt_a [AXES];

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign in_stall  = busy_reg;
    assign accept    = in_valid && !in_stall;

    // Register writes keep the low bits
    always_comb
    begin
        vm_next = vm_reg;
        vp_next = vp_reg;
        iv_next = iv_reg;
        if (cfg_wr)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_MEAS_VAR: vm_next = cfg_data[CFG_W-1:0];
                REG_PROC_VAR: vp_next = cfg_data[CFG_W-1:0];
                REG_INIT_VAR: iv_next = cfg_data[CFG_W-1:0];
                default:      ;
            endcase
        end
    end

    // One request in work until the merge stage takes the lane results
    assign busy_next = accept ? 1'b1 : (load ? 1'b0 : busy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg   <= VM_RESET;
            vp_reg   <= VP_RESET;
            iv_reg   <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            vm_reg   <= vm_next;
            vp_reg   <= vp_next;
            iv_reg   <= iv_next;
            busy_reg <= busy_next;
        end
    end

    assign ctl.start = accept;
    assign ctl.init  = action;
    assign ctl.ack   = load;

    assign obs_a[0] = obs_x;
    assign obs_a[1] = obs_y;
    assign obs_a[2] = obs_z;
    assign dlt_a[0] = delta_x;
    assign dlt_a[1] = delta_y;
    assign dlt_a[2] = delta_z;

    // One filter lane per axis
    for (genvar i = 0; i < AXES; i++)
    begin : g_lane
        k1d_lane #(
            .POS_WIDTH (POS_WIDTH)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .obs     (obs_a[i]),
            .dlt     (dlt_a[i]),
            .vm      (vm_reg),
            .vp      (vp_reg),
            .iv      (iv_reg),
            .done    (lane_done[i]),
            .est     (lane_est[i]),
            .var_out (lane_var[i])
        );
    end

    k1d_merge u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .lane_done (lane_done),
        .lane_est  (lane_est),
        .lane_var  (lane_var),
        .out_stall (out_stall),
        .load      (load),
        .out_valid (out_valid),
        .est_x     (est_x),
        .est_y     (est_y),
        .est_z     (est_z),
        .var_x     (var_x),
        .var_y     (var_y),
        .var_z     (var_z)
    );

endmodule

/* rtl/k1d_lane.sv */
module k1d_lane #(
    parameter int POS_WIDTH = k1d_pkg::POS_WIDTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  k1d_pkg::lane_ctl_t                    ctl,
    input  logic signed [k1d_pkg::FIELD_W-1:0]    obs,
    input  logic signed [k1d_pkg::FIELD_W-1:0]    dlt,
    input  logic        [k1d_pkg::CFG_W-1:0]      vm,
    input  logic        [k1d_pkg::CFG_W-1:0]      vp,
    input  logic        [k1d_pkg::CFG_W-1:0]      iv,
    output logic                                  done,
    output logic signed [k1d_pkg::FIELD_W-1:0]    est,
    output logic        [k1d_pkg::VAR_W-1:0]      var_out
);
    import k1d_pkg::*;

    // Working widths: XW holds any position sum, NW any blend numerator
    localparam int XW = ((POS_WIDTH > FIELD_W) ? POS_WIDTH : FIELD_W) + 2;
    localparam int DW = VAR_W + 2;
    localparam int RW = DW + 1;
    localparam int NW = XW + DW;
    localparam int CW = $clog2(NW);

    typedef enum logic [2:0] {
        L_IDLE, L_MUL, L_DIV, L_FIN1, L_FIN2, L_DONE
    } lane_state_t;

    lane_state_t                  state_reg, state_next;
    logic                         phase_reg, phase_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic [NW-1:0]                acc_reg, acc_next;
    logic [NW-1:0]                mcand_reg, mcand_next;
    logic [VAR_W-1:0]             mplier_reg, mplier_next;
    logic [NW-1:0]                num_reg, num_next;
    logic [RW-1:0]                rem_reg, rem_next;
    logic                         neg_reg, neg_next;
    logic [XW-1:0]                off_reg, off_next;
    logic [VAR_W-1:0]             nv_reg, nv_next;
    logic signed [POS_WIDTH-1:0]  p_reg, p_next;
    logic [VAR_W-1:0]             v_reg, v_next;
    logic signed [FIELD_W-1:0]    dlt_reg, dlt_next;

    logic [DW-2:0]                d;
    logic [DW-1:0]                dv;
    logic signed [XW-1:0]         p_x, o_x, diff, dlt_x, blend_sum, pred_sum;
    logic [XW-1:0]                mag;
    logic [NW-1:0]                acc_add;
    logic [RW-1:0]                rem_sh;
    logic                         qbit;
    logic [VAR_W:0]               vsum;

    function automatic logic signed [POS_WIDTH-1:0] sat_pos(input logic signed [XW-1:0] x);
        logic signed [XW-1:0] hi;
        logic signed [XW-1:0] lo;
        hi = {{(XW-POS_WIDTH+1){1'b0}}, {(POS_WIDTH-1){1'b1}}};
        lo = ~hi;
        if (x > hi)
            sat_pos = hi[POS_WIDTH-1:0];
        else if (x < lo)
            sat_pos = lo[POS_WIDTH-1:0];
        else
            sat_pos = x[POS_WIDTH-1:0];
    endfunction

    // Operand prep
    assign d         = {1'b0, v_reg} + {2'b00, vm};
    assign dv        = {d, 1'b0};
    assign p_x       = {{(XW-POS_WIDTH){p_reg[POS_WIDTH-1]}}, p_reg};
    assign o_x       = {{(XW-FIELD_W){obs[FIELD_W-1]}}, obs};
    assign dlt_x     = {{(XW-FIELD_W){dlt_reg[FIELD_W-1]}}, dlt_reg};
    assign diff      = o_x - p_x;
    assign mag       = diff[XW-1] ? (p_x - o_x) : diff;
    assign blend_sum = neg_reg ? (p_x - off_reg) : (p_x + off_reg);
    assign pred_sum  = p_x + dlt_x;
    assign vsum      = {1'b0, v_reg} + {2'b00, vp};

    // Shift-add and restoring-divide steps
    assign acc_add = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
    assign rem_sh  = {rem_reg[RW-2:0], num_reg[NW-1]};
    assign qbit    = (rem_sh >= {1'b0, dv});

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        neg_next    = neg_reg;
        off_next    = off_reg;
        nv_next     = nv_reg;
        p_next      = p_reg;
        v_next      = v_reg;
        dlt_next    = dlt_reg;
        case (state_reg)
            L_IDLE:
            begin
                if (ctl.start)
                begin
                    dlt_next = dlt;
                    if (ctl.init)
                    begin
                        p_next     = sat_pos(o_x);
                        v_next     = {1'b0, iv};
                        state_next = L_DONE;
                    end
                    else if (d == '0)
                    begin
                        // nothing to blend: keep estimate, predict only
                        off_next   = '0;
                        neg_next   = 1'b0;
                        nv_next    = v_reg;
                        state_next = L_FIN1;
                    end
                    else
                    begin
                        neg_next    = diff[XW-1];
                        acc_next    = '0;
                        mcand_next  = {{(NW-XW){1'b0}}, mag};
                        mplier_next = v_reg;
                        cnt_next    = '0;
                        phase_next  = 1'b0;
                        state_next  = L_MUL;
                    end
                end
            end
            L_MUL:
            begin
                acc_next    = acc_add;
                mcand_next  = {mcand_reg[NW-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[VAR_W-1:1]};
                cnt_next    = cnt_reg + 1'b1;
                if (cnt_reg == CW'(VAR_W-1))
                begin
                    // numerator 2*a*b + d, rounds to nearest
                    num_next   = {acc_add[NW-2:0], 1'b0} + {{(NW-DW+1){1'b0}}, d};
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = L_DIV;
                end
            end
            L_DIV:
            begin
                rem_next = qbit ? (rem_sh - {1'b0, dv}) : rem_sh;
                num_next = {num_reg[NW-2:0], qbit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW-1))
                begin
                    if (!phase_reg)
                    begin
                        off_next    = num_next[XW-1:0];
                        acc_next    = '0;
                        mcand_next  = {{(NW-CFG_W){1'b0}}, vm};
                        mplier_next = v_reg;
                        cnt_next    = '0;
                        phase_next  = 1'b1;
                        state_next  = L_MUL;
                    end
                    else
                    begin
                        nv_next    = num_next[VAR_W-1:0];
                        state_next = L_FIN1;
                    end
                end
            end
            L_FIN1:
            begin
                p_next     = sat_pos(blend_sum);
                v_next     = nv_reg;
                state_next = L_FIN2;
            end
            L_FIN2:
            begin
                p_next     = sat_pos(pred_sum);
                v_next     = vsum[VAR_W] ? VAR_MAX : vsum[VAR_W-1:0];
                state_next = L_DONE;
            end
            L_DONE:
            begin
                if (ctl.ack)
                    state_next = L_IDLE;
            end
            default:
                state_next = L_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= L_IDLE;
            p_reg     <= '0;
            v_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            p_reg     <= p_next;
            v_reg     <= v_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        phase_reg  <= phase_next;
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        neg_reg    <= neg_next;
        off_reg    <= off_next;
        nv_reg     <= nv_next;
        dlt_reg    <= dlt_next;
    end

    assign done    = (state_reg == L_DONE);
    assign est     = p_x[FIELD_W-1:0];
    assign var_out = v_reg;

endmodule

/* rtl/k1d_merge.sv */
module k1d_merge (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [k1d_pkg::AXES-1:0]            lane_done,
    input  logic signed [k1d_pkg::FIELD_W-1:0]  lane_est [k1d_pkg::AXES],
    input  logic        [k1d_pkg::VAR_W-1:0]    lane_var [k1d_pkg::AXES],
    input  logic                                out_stall,
    output logic                                load,
    output logic                                out_valid,
    output logic signed [k1d_pkg::FIELD_W-1:0]  est_x,
    output logic signed [k1d_pkg::FIELD_W-1:0]  est_y,
    output logic signed [k1d_pkg::FIELD_W-1:0]  est_z,
    output logic        [k1d_pkg::VAR_W-1:0]    var_x,
    output logic        [k1d_pkg::VAR_W-1:0]    var_y,
    output logic        [k1d_pkg::VAR_W-1:0]    var_z
);
    import k1d_pkg::*;

    logic                       valid_reg, valid_next;
    logic signed [FIELD_W-1:0]  est_reg [AXES];
    logic        [VAR_W-1:0]    var_reg [AXES];

    // Take the lane results once all lanes finish and the slot is free
    assign load       = (&lane_done) && (!valid_reg || !out_stall);
    assign valid_next = load ? 1'b1 : (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            est_reg <= lane_est;
            var_reg <= lane_var;
        end
    end

    assign out_valid = valid_reg;
    assign est_x     = est_reg[0];
    assign est_y     = est_reg[1];
    assign est_z     = est_reg[2];
    assign var_x     = var_reg[0];
    assign var_y     = var_reg[1];
    assign var_z     = var_reg[2];

endmodule

/* rtl/k1d_checker.sv */
`include "assert_macros.svh"

module k1d_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall
);

    // A request in work holds off the next one
    `AST_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    // A new result only comes from a request in work
    `AST_SAME(a_result_from_work, $rose(out_valid), $past(in_stall))
    // A stalled result is not dropped
    `AST_NEXT(a_out_hold, out_valid && out_stall, out_valid)

endmodule

bind kalman_1d_three_axis_top k1d_checker u_k1d_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall)
);
